>>> rtl/tis_pkg.sv
package tis_pkg;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam int LETTER_W = 5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_MARK,
        ST_EMIT
    } state_t;

endpackage

>>> rtl/trie_insert_search_core.sv
// letter beat that fails early (failed word or letter out of range): taken in ST_IDLE with no walk
// letter beat that walks the trie: child-table read, then update in ST_LOOK
// last search letter: the end-mark read follows the child read, result in ST_MARK
// clear: a sweep over all NODE_COUNT*ALPHABET_SIZE entries (26624 at defaults) of the child table
// reset starts the same sweep; no input beat is taken until it ends
// one beat in flight at a time; a finished result waits in the output register
module trie_insert_search_core #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // letter[4:0], zero pad
    input  logic [1:0] s_tuser,   // req_type[1:0]
    input  logic       s_tlast,   // last_letter
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // found[0], overflow[1], zero pad
    output logic [1:0] m_tuser    // op_done[1:0]
);
    import tis_pkg::*;

    localparam int NODE_W    = $clog2(NODE_COUNT);
    localparam int CNT_W     = $clog2(NODE_COUNT + 1);
    localparam int TBL_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int TBL_W     = $clog2(TBL_DEPTH);

    logic [NODE_W-1:0] child_table [TBL_DEPTH];
    logic              end_marks   [NODE_COUNT];

    state_t            state_reg, state_next;
    logic [NODE_W-1:0] cursor_reg, cursor_next;
    logic              failed_reg, failed_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [TBL_W-1:0]  clr_idx_reg, clr_idx_next;
    logic              clr_res_reg, clr_res_next;
    logic [TBL_W-1:0]  slot_reg, slot_next;
    logic [1:0]        kind_reg, kind_next;
    logic              last_reg, last_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic              out_ovf_reg, out_ovf_next;
    logic [1:0]        out_op_reg, out_op_next;
    logic              pend_found_reg, pend_found_next;
    logic              pend_ovf_reg, pend_ovf_next;
    logic [1:0]        pend_op_reg, pend_op_next;

    logic              ct_we;
    logic [TBL_W-1:0]  ct_addr;
    logic [NODE_W-1:0] ct_wdata;
    logic [NODE_W-1:0] ct_rdata;
    logic              em_we;
    logic [NODE_W-1:0] em_addr;
    logic              em_wdata;
    logic              em_rdata;

    logic              in_fire;
    logic              out_free;
    logic              is_walk;
    logic              early_fail;
    logic              clr_done;
    logic              child_none;
    logic              look_fail;
    logic [NODE_W-1:0] new_node;
    logic [TBL_W-1:0]  slot_idx;
    logic              res_go;
    logic              res_found;
    logic              res_ovf;
    logic [1:0]        res_op;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_found_reg};
    assign m_tuser  = out_op_reg;

    assign is_walk    = (s_tuser == REQ_INSERT) || (s_tuser == REQ_SEARCH);
    assign early_fail = failed_reg || (32'(s_tdata[LETTER_W-1:0]) >= ALPHABET_SIZE);
    assign clr_done   = (clr_idx_reg == TBL_W'(TBL_DEPTH - 1));
    assign child_none = (ct_rdata == '0);
    assign look_fail  = child_none &&
                        ((kind_reg == REQ_SEARCH) || (free_reg >= CNT_W'(NODE_COUNT)));
    assign new_node   = child_none ? free_reg[NODE_W-1:0] : ct_rdata;
    assign slot_idx   = TBL_W'(TBL_W'(cursor_reg) * TBL_W'(ALPHABET_SIZE))
                        + TBL_W'(s_tdata[LETTER_W-1:0]);

    // result decode
    always_comb
    begin
        res_go    = 1'b0;
        res_found = 1'b0;
        res_ovf   = 1'b0;
        res_op    = kind_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                res_go = clr_done && clr_res_reg;
                res_op = REQ_CLEAR;
            end
            ST_IDLE:
            begin
                res_go  = in_fire && is_walk && early_fail && s_tlast;
                res_ovf = (s_tuser == REQ_INSERT);
                res_op  = s_tuser;
            end
            ST_LOOK:
            begin
                res_go  = last_reg && (look_fail || (kind_reg == REQ_INSERT));
                res_ovf = look_fail && (kind_reg == REQ_INSERT);
            end
            ST_MARK:
            begin
                res_go    = 1'b1;
                res_found = em_rdata;
                res_op    = REQ_SEARCH;
            end
            default:
            begin
                res_go = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == REQ_CLEAR))
                begin
                    state_next = ST_CLEAR;
                end
                else if (in_fire && is_walk && !early_fail)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (last_reg && !look_fail && (kind_reg == REQ_SEARCH))
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MARK:
            begin
                state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (res_go && !out_free)
        begin
            state_next = ST_EMIT;
        end
    end

    // datapath and memory controls
    always_comb
    begin
        cursor_next     = cursor_reg;
        failed_next     = failed_reg;
        free_next       = free_reg;
        clr_idx_next    = clr_idx_reg;
        clr_res_next    = clr_res_reg;
        slot_next       = slot_reg;
        kind_next       = kind_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_ovf_next    = out_ovf_reg;
        out_op_next     = out_op_reg;
        pend_found_next = pend_found_reg;
        pend_ovf_next   = pend_ovf_reg;
        pend_op_next    = pend_op_reg;
        ct_we           = 1'b0;
        ct_addr         = slot_idx;
        ct_wdata        = '0;
        em_we           = 1'b0;
        em_addr         = new_node;
        em_wdata        = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ct_we        = 1'b1;
                ct_addr      = clr_idx_reg;
                em_we        = (clr_idx_reg < TBL_W'(NODE_COUNT));
                em_addr      = clr_idx_reg[NODE_W-1:0];
                clr_idx_next = clr_idx_reg + TBL_W'(1);
                if (clr_done)
                begin
                    clr_res_next = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == REQ_CLEAR))
                begin
                    cursor_next  = '0;
                    failed_next  = 1'b0;
                    free_next    = CNT_W'(1);
                    clr_idx_next = '0;
                    clr_res_next = 1'b1;
                end
                else if (in_fire && is_walk)
                begin
                    slot_next = slot_idx;
                    kind_next = s_tuser;
                    last_next = s_tlast;
                    if (early_fail)
                    begin
                        failed_next = !s_tlast;
                        if (s_tlast)
                        begin
                            cursor_next = '0;
                        end
                    end
                end
            end
            ST_LOOK:
            begin
                if (look_fail)
                begin
                    failed_next = !last_reg;
                    if (last_reg)
                    begin
                        cursor_next = '0;
                    end
                end
                else
                begin
                    cursor_next = new_node;
                    if (child_none)
                    begin
                        ct_we     = 1'b1;
                        ct_addr   = slot_reg;
                        ct_wdata  = new_node;
                        free_next = free_reg + CNT_W'(1);
                    end
                    if (last_reg && (kind_reg == REQ_INSERT))
                    begin
                        em_we       = 1'b1;
                        em_wdata    = 1'b1;
                        cursor_next = '0;
                    end
                end
            end
            ST_MARK:
            begin
                cursor_next = '0;
                failed_next = 1'b0;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = pend_found_reg;
                    out_ovf_next   = pend_ovf_reg;
                    out_op_next    = pend_op_reg;
                end
            end
            default:
            begin
                cursor_next = cursor_reg;
            end
        endcase
        if (res_go)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                out_found_next = res_found;
                out_ovf_next   = res_ovf;
                out_op_next    = res_op;
            end
            else
            begin
                pend_found_next = res_found;
                pend_ovf_next   = res_ovf;
                pend_op_next    = res_op;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
        begin
            child_table[ct_addr] <= ct_wdata;
        end
        ct_rdata <= child_table[ct_addr];
    end

    always_ff @(posedge clk)
    begin
        if (em_we)
        begin
            end_marks[em_addr] <= em_wdata;
        end
        em_rdata <= end_marks[em_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cursor_reg    <= '0;
            failed_reg    <= 1'b0;
            free_reg      <= CNT_W'(1);
            clr_idx_reg   <= '0;
            clr_res_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            failed_reg    <= failed_next;
            free_reg      <= free_next;
            clr_idx_reg   <= clr_idx_next;
            clr_res_reg   <= clr_res_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        kind_reg       <= kind_next;
        last_reg       <= last_next;
        out_found_reg  <= out_found_next;
        out_ovf_reg    <= out_ovf_next;
        out_op_reg     <= out_op_next;
        pend_found_reg <= pend_found_next;
        pend_ovf_reg   <= pend_ovf_next;
        pend_op_reg    <= pend_op_next;
    end

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(NODE_COUNT))
        else $error("allocator ran past the node pool");

    a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(cursor_reg) < free_reg)
        else $error("cursor points at an unallocated node");

    a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == REQ_CLEAR)) |=> (state_reg == ST_CLEAR))
        else $error("clear beat did not start the sweep");

    a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tuser == REQ_SEARCH))
        else $error("found set on a non-search result");

endmodule

>>> verif/trie_insert_search_core_test.sv
module trie_insert_search_core_test;
    import tis_pkg::*;

    localparam int NODE_COUNT = 1024;
    localparam int ALPHA = 26;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT = 60000;

    typedef struct packed {
        logic       found;
        logic       overflow;
        logic [1:0] op_done;
    } trie_result_t;

    class trie_scoreboard;
        logic [9:0]   child_ptr[NODE_COUNT * ALPHA];
        bit           end_mark[NODE_COUNT];
        logic [9:0]   cursor;
        bit           word_failed;
        logic [10:0]  nodes_used;
        trie_result_t awaited[$];
        int           mismatches;
        int           results_seen;
        int           hits;
        int           overflows;
        int           clears;

        function new();
            mismatches = 0;
            results_seen = 0;
            hits = 0;
            overflows = 0;
            clears = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (child_ptr[i])
                child_ptr[i] = '0;
            foreach (end_mark[i])
                end_mark[i] = 1'b0;
            cursor = '0;
            word_failed = 1'b0;
            nodes_used = 11'd1;
        endfunction

        function void note_beat(logic [1:0] req, logic [4:0] letter, logic last);
            trie_result_t r;
            int unsigned slot;
            if (req == REQ_CLEAR)
            begin
                wipe();
                clears++;
                r = '{found: 1'b0, overflow: 1'b0, op_done: REQ_CLEAR};
                awaited.push_back(r);
                return;
            end
            if (req != REQ_INSERT && req != REQ_SEARCH)
                return;
            if (!word_failed)
            begin
                if (letter >= ALPHA)
                    word_failed = 1'b1;
                else
                begin
                    slot = int'(cursor) * ALPHA + int'(letter);
                    if (child_ptr[slot] != '0)
                        cursor = child_ptr[slot];
                    else if (req == REQ_SEARCH || nodes_used >= NODE_COUNT)
                        word_failed = 1'b1;
                    else
                    begin
                        child_ptr[slot] = nodes_used[9:0];
                        nodes_used++;
                        cursor = child_ptr[slot];
                    end
                end
            end
            if (!last)
                return;
            if (req == REQ_INSERT)
            begin
                if (!word_failed)
                    end_mark[cursor] = 1'b1;
                r = '{found: 1'b0, overflow: word_failed, op_done: REQ_INSERT};
            end
            else
                r = '{found: !word_failed && end_mark[cursor], overflow: 1'b0,
                      op_done: REQ_SEARCH};
            cursor = '0;
            word_failed = 1'b0;
            awaited.push_back(r);
        endfunction

        function void check_result(logic [7:0] tdata, logic [1:0] tuser);
            trie_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: tdata %h tuser %0d", tdata, tuser);
                return;
            end
            want = awaited.pop_front();
            results_seen++;
            if (tdata[0] !== want.found || tdata[1] !== want.overflow ||
                tdata[7:2] !== 6'd0 || tuser !== want.op_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected found/ovf/op %b/%b/%0d, got %b/%b/%0d pad %h",
                             results_seen, want.found, want.overflow, want.op_done,
                             tdata[0], tdata[1], tuser, tdata[7:2]);
            end
            else
            begin
                if (want.found)
                    hits++;
                if (want.overflow)
                    overflows++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [1:0] s_tuser = 2'd0;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;

    trie_scoreboard sb;
    int          cycles = 0;
    int          beats_sent = 0;
    int          burst_left = 0;
    bit          steady_send = 1'b0;
    int          clears_left = 0;
    int          hold_asks = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          mode_left = 0;
    int          stall_mode = 0;
    int          rx_tick = 0;
    logic [39:0] saved_words[$];
    int          saved_lens[$];

    trie_insert_search_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("trie_insert_search_core verification failed");
            $finish;
        end
    end

    // receiver: long hold on request, otherwise a changing stall pattern
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(16, 96);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) >= 40);
                2: m_tready <= (rx_tick % 4 != 3);
                default: m_tready <= ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = steady_send ? 0 : $urandom_range(1, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_beat(input logic [1:0] req, input logic [4:0] letter,
                             input logic last);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {3'b000, letter};
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_beat(req, letter, last);
        if (req != REQ_SPARE)
            beats_sent++;
        pace_sender();
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic random_word();
        logic [39:0] w;
        int          len;
        int          pick;
        int          k;
        logic [1:0]  kind;
        logic [1:0]  req;
        bit          mixed;
        pick = $urandom_range(0, 99);
        if (pick < 3 && clears_left > 0)
        begin
            clears_left--;
            send_beat(REQ_CLEAR, 5'($urandom), 1'($urandom));
            return;
        end
        if (pick < 6)
        begin
            send_beat(REQ_SPARE, 5'($urandom), 1'($urandom));
            return;
        end
        if (saved_words.size() > 0 && pick < 40)
        begin
            k = $urandom_range(0, saved_words.size() - 1);
            w = saved_words[k];
            len = saved_lens[k];
        end
        else
        begin
            len = $urandom_range(1, 8);
            w = '0;
            for (int i = 0; i < len; i++)
                w[5*i +: 5] = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 3))
                                                           : 5'($urandom_range(0, 25));
        end
        if (pick >= 94)
            w[5*$urandom_range(0, len - 1) +: 5] = 5'($urandom_range(26, 31));
        mixed = (pick >= 88 && pick < 94);
        kind = $urandom_range(0, 1) ? REQ_INSERT : REQ_SEARCH;
        for (int i = 0; i < len; i++)
        begin
            req = kind;
            if (mixed)
                req = $urandom_range(0, 1) ? REQ_INSERT : REQ_SEARCH;
            send_beat(req, w[5*i +: 5], i == len - 1);
        end
        if (kind == REQ_INSERT && !mixed && saved_words.size() < 64)
        begin
            saved_words.push_back(w);
            saved_lens.push_back(len);
        end
    endtask

    task automatic fill_word();
        int len;
        len = $urandom_range(8, 40);
        for (int i = 0; i < len; i++)
            send_beat(REQ_INSERT, 5'($urandom_range(0, 25)), i == len - 1);
    endtask

    initial
    begin
        int k;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed words
        send_beat(REQ_SEARCH, 0, 1);
        send_beat(REQ_INSERT, 25, 1);
        send_beat(REQ_SEARCH, 25, 1);
        send_beat(REQ_INSERT, 0, 0);
        send_beat(REQ_INSERT, 1, 1);
        send_beat(REQ_SEARCH, 0, 1);
        send_beat(REQ_SEARCH, 0, 0);
        send_beat(REQ_SEARCH, 1, 1);
        send_beat(REQ_INSERT, 31, 1);
        send_beat(REQ_SEARCH, 26, 0);
        send_beat(REQ_SEARCH, 0, 1);
        send_beat(REQ_INSERT, 0, 0);
        send_beat(REQ_SEARCH, 1, 1);
        send_beat(REQ_SEARCH, 0, 0);
        send_beat(REQ_INSERT, 2, 1);
        send_beat(REQ_SPARE, 5, 1);
        send_beat(REQ_SPARE, 30, 0);
        send_beat(REQ_CLEAR, 31, 0);
        send_beat(REQ_SEARCH, 0, 0);
        send_beat(REQ_SEARCH, 1, 1);
        send_beat(REQ_INSERT, 25, 0);
        send_beat(REQ_INSERT, 0, 1);
        drain();

        // short words over a narrow alphabet so searches hit often
        clears_left = 3;
        for (int n = 0; beats_sent < 130; n++)
        begin
            if (n == 10)
                hold_asks <= hold_asks + 1;
            steady_send = (n >= 10 && n < 18) || ($urandom_range(0, 9) == 0);
            random_word();
        end
        steady_send = 1'b0;
        drain();

        // long random inserts until the node pool runs dry, then inserts and searches on the full pool
        while (sb.nodes_used < NODE_COUNT)
        begin
            steady_send = ($urandom_range(0, 9) == 0);
            fill_word();
        end
        steady_send = 1'b0;
        for (int n = 0; n < 18; n++)
        begin
            k = $urandom_range(0, saved_words.size() - 1);
            case (n % 3)
                0:
                begin
                    for (int i = 0; i < 3; i++)
                        send_beat(REQ_INSERT, 5'($urandom_range(0, 25)), i == 2);
                end
                1:
                begin
                    for (int i = 0; i < saved_lens[k]; i++)
                        send_beat(REQ_INSERT, saved_words[k][5*i +: 5], i == saved_lens[k] - 1);
                end
                default:
                begin
                    for (int i = 0; i < saved_lens[k]; i++)
                        send_beat(REQ_SEARCH, saved_words[k][5*i +: 5], i == saved_lens[k] - 1);
                end
            endcase
        end
        drain();

        // pool reuse after a clear
        send_beat(REQ_CLEAR, 5'($urandom), 1'($urandom));
        clears_left = 0;
        for (int n = 0; n < 10; n++)
            random_word();

        drain();
        repeat (30) @(posedge clk);
        $display("covered %0d letter beats, %0d results, %0d clears, %0d hits, %0d overflows",
                 beats_sent, sb.results_seen, sb.clears, sb.hits, sb.overflows);
        $display("pool filled to %0d nodes once, %0d mismatches", NODE_COUNT, sb.mismatches);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("trie_insert_search_core verification clean");
        else
        begin
            if (sb.awaited.size() != 0)
                $display("%0d expected results never arrived", sb.awaited.size());
            $display("trie_insert_search_core verification failed");
        end
        $finish;
    end
endmodule
